// File: hdl/bds_pkg.sv
// bds_pkg: shared types and constants of the 4x4 box downscaler.
// No dependencies; imported by bds_front, bds_back and the top level.
package bds_pkg;

	localparam int LANES                = 4;
	localparam int CH_W                 = 8;
	localparam int PIXEL_W              = LANES * CH_W;
	localparam int HSUM_LANE_W          = 10;
	localparam int VSUM_LANE_W          = 12;
	localparam int CFG_W                = 12;
	localparam int CFG_INDEX_W          = 1;
	localparam int DEF_MAX_REGION_WIDTH = 2048;
	localparam int DEF_QUEUE_DEPTH      = 4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_REGION_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_REGION_HEIGHT = 1'b1;

	typedef logic [LANES-1:0][HSUM_LANE_W-1:0] hsum_t;
	typedef logic [LANES-1:0][VSUM_LANE_W-1:0] vsum_t;

	// one line-store update, issued by the front on every fourth pixel of a tile row
	typedef struct packed {
		hsum_t hsum;
		logic  first_row;
		logic  emit;
		logic  last;
	} op_t;

endpackage

// File: hdl/bds_ram.sv
// bds_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bds_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/bds_front.sv
// bds_front: pixel acceptance, column/row counting and horizontal sums.
// Depends on bds_pkg; feeds bds_queue with line-store update transactions.
module bds_front import bds_pkg::*; #(
	parameter int MAX_REGION_WIDTH = DEF_MAX_REGION_WIDTH,
	localparam int DEPTH = MAX_REGION_WIDTH / 4,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW    = $clog2(MAX_REGION_WIDTH),
	localparam int WW    = $clog2(MAX_REGION_WIDTH + 1),
	localparam int CMPW  = (WW > CFG_W) ? WW : CFG_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CFG_W-1:0]   region_width,
	input  logic [CFG_W-1:0]   region_height,
	input  logic               in_valid,
	input  logic [PIXEL_W-1:0] in_pixel,
	output logic               in_stall,
	input  logic               q_full,
	output logic               q_push,
	output logic [AW-1:0]      q_idx,
	output op_t                q_op
);

	logic [CW-1:0]    col_q;
	logic [CFG_W-1:0] row_q;
	hsum_t            hsum_q;

	logic [CMPW-1:0]  w_cap;
	logic [WW-1:0]    w;
	logic [WW-1:0]    w_tiles;
	logic [WW-1:0]    col_ext;
	logic [WW-1:0]    col_inc;
	logic [CFG_W:0]   row_inc;
	logic [CFG_W-1:0] h_tiles;
	logic             accept;
	logic             zero_size;
	logic             in_tile;
	logic             col_wrap;
	hsum_t            hsum_d;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// width clamp to the line-store span
	assign w_cap = (CMPW'(region_width) > CMPW'(MAX_REGION_WIDTH))
		? CMPW'(MAX_REGION_WIDTH) : CMPW'(region_width);
	assign w       = WW'(w_cap);
	assign w_tiles = w >> 2;
	assign h_tiles = region_height >> 2;

	assign zero_size = (w == '0) || (region_height == '0);
	assign col_ext   = WW'(col_q);
	assign col_inc   = col_ext + WW'(1);
	assign row_inc   = {1'b0, row_q} + (CFG_W+1)'(1);
	assign col_wrap  = (col_inc >= w);
	assign in_tile   = ((col_ext >> 2) < w_tiles) && ((row_q >> 2) < h_tiles);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			hsum_d[k] = ((col_q[1:0] == 2'b00) ? '0 : hsum_q[k])
				+ HSUM_LANE_W'(in_pixel[k*CH_W +: CH_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			hsum_q <= '0;
		end else if (accept && !zero_size) begin
			if (in_tile) begin
				hsum_q <= hsum_d;
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= (row_inc >= (CFG_W+1)'(region_height)) ? '0 : CFG_W'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	assign q_push         = accept && !zero_size && in_tile && (col_q[1:0] == 2'b11);
	assign q_idx          = AW'(col_q >> 2);
	assign q_op.hsum      = hsum_d;
	assign q_op.first_row = (row_q[1:0] == 2'b00);
	assign q_op.emit      = (row_q[1:0] == 2'b11);
	assign q_op.last      = ((col_ext >> 2) == (w_tiles - WW'(1)))
		&& ((row_q >> 2) == (h_tiles - CFG_W'(1)));

endmodule

// File: hdl/bds_queue.sv
// bds_queue: small register FIFO between front and back.
// No dependencies; depth must be a power of two, at least two.
module bds_queue #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 4,
	localparam int PW   = $clog2(DEPTH),
	localparam int NW   = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [NW-1:0]    count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// File: hdl/bds_back.sv
// bds_back: line-store read-modify-write and the output register.
// Depends on bds_pkg and bds_ram; drains bds_queue.
module bds_back import bds_pkg::*; #(
	parameter int MAX_REGION_WIDTH = DEF_MAX_REGION_WIDTH,
	localparam int DEPTH = MAX_REGION_WIDTH / 4,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  logic [AW-1:0]      q_idx,
	input  op_t                q_op,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIXEL_W-1:0] out_pixel,
	output logic               frame_last
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_UPD  = 2'b10
	} bstate_t;

	bstate_t              state_q;
	op_t                  op_q;
	logic [AW-1:0]        idx_q;
	logic                 out_valid_q;
	logic [PIXEL_W-1:0]   out_pixel_q;
	logic                 frame_last_q;

	logic [$bits(vsum_t)-1:0] ram_rdata;
	vsum_t                    entry_old;
	vsum_t                    entry_new;
	logic [PIXEL_W-1:0]       avg;
	logic                     advance;
	logic                     load_out;

	bds_ram #(
		.WIDTH($bits(vsum_t)),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (advance),
		.waddr (idx_q),
		.wdata (entry_new),
		.re    (q_pop),
		.raddr (q_idx),
		.rdata (ram_rdata)
	);

	assign entry_old = ram_rdata;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			entry_new[k] = (op_q.first_row ? '0 : entry_old[k])
				+ VSUM_LANE_W'(op_q.hsum[k]);
			avg[k*CH_W +: CH_W] = entry_new[k][VSUM_LANE_W-1 -: CH_W];
		end
	end

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	// hold the update while a finished pixel is still waiting downstream
	assign advance  = (state_q == B_UPD) && (!op_q.emit || !out_valid_q || !out_stall);
	assign load_out = advance && op_q.emit;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q  <= q_op;
			idx_q <= q_idx;
		end
		if (load_out) begin
			out_pixel_q  <= avg;
			frame_last_q <= op_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						state_q <= B_UPD;
					end
				end
				B_UPD: begin
					if (advance) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign frame_last = frame_last_q;

	a_pop_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == B_UPD))
		else $error("pop not followed by update");

	a_held_update_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UPD && !advance) |=> (state_q == B_UPD && $stable(op_q) && $stable(idx_q)))
		else $error("held update changed");

	a_emit_shows_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("emitted pixel not presented");

endmodule

// File: hdl/box_downscale_4x4_rgba.sv
// box_downscale_4x4_rgba: top level of the 4x4 box-filter downscaler.
// Depends on bds_pkg, bds_front, bds_queue, bds_back (and bds_ram through it).
//
// Source pixels (four 8-bit channels, bits 31:24 first) arrive in raster order, one
// transaction per clock while in_stall is low; each 4x4 tile yields one pixel whose
// channels are the truncated average of the 16 inputs, and the last tile of a frame
// raises frame_last. The front counts columns and rows and sums four pixels of a tile
// row; every fourth pixel it hands a line-store update to a four-entry queue. The back
// does a read-modify-write (read in B_IDLE, write in B_UPD) of partial column sums in
// a RAM of MAX_REGION_WIDTH/4 entries and loads the output register on the bottom row
// of a band. As updates come at most one in four pixels, the sustained rate is one pixel
// per cycle while out_stall is low; out_valid rises after the queue, B_IDLE and B_UPD,
// later only while out_stall holds the back. in_stall rises only when the queue fills,
// i.e. when out_stall has been held long enough. Remainder columns and rows are consumed
// and dropped; a width or height of zero consumes pixels with no effect; widths above
// MAX_REGION_WIDTH are clamped. The line store needs no clearing after reset: the first
// row of each band overwrites an entry before it is read. Registers (index 0 width,
// index 1 height, 12 bits) are always ready and should be written only while idle.
module box_downscale_4x4_rgba import bds_pkg::*; #(
	parameter int MAX_REGION_WIDTH = DEF_MAX_REGION_WIDTH,
	parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// source pixels
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PIXEL_W-1:0]     in_pixel,
	// downscaled pixels
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PIXEL_W-1:0]     out_pixel,
	output logic                   frame_last
);

	localparam int DEPTH = MAX_REGION_WIDTH / 4;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW    = AW + $bits(op_t);

	logic [CFG_W-1:0] region_width_q;
	logic [CFG_W-1:0] region_height_q;

	// front to queue
	logic          push;
	logic [AW-1:0] push_idx;
	op_t           push_op;
	// queue to back
	logic          pop;
	logic          q_full;
	logic          q_empty;
	logic [QW-1:0] q_rdata;
	logic [AW-1:0] head_idx;
	op_t           head_op;

	// registers take writes at any time; no back-pressure needed
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_width_q  <= '0;
			region_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REGION_WIDTH:  region_width_q  <= cfg_data;
				REG_REGION_HEIGHT: region_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bds_front #(
		.MAX_REGION_WIDTH(MAX_REGION_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.region_width  (region_width_q),
		.region_height (region_height_q),
		.in_valid      (in_valid),
		.in_pixel      (in_pixel),
		.in_stall      (in_stall),
		.q_full        (q_full),
		.q_push        (push),
		.q_idx         (push_idx),
		.q_op          (push_op)
	);

	bds_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_idx, push_op}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign head_idx = q_rdata[QW-1 -: AW];
	assign head_op  = q_rdata[$bits(op_t)-1:0];

	bds_back #(
		.MAX_REGION_WIDTH(MAX_REGION_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_idx      (head_idx),
		.q_op       (head_op),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel),
		.frame_last (frame_last)
	);

endmodule
